/* sv/qett_pkg.sv */
// shared types, constants and microcode program for the quaternion escape-time test
package qett_pkg;

  localparam int unsigned MAXIT_W    = 8;
  localparam int unsigned LIMIT_W    = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned PC_W       = 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [PC_W-1:0]      pc_t;
  typedef logic [1:0]           zsel_t;

  // register indexes of the configuration port
  localparam cfg_idx_t CFG_MAX_ITER = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_ESC_LIM  = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_INS_LIM  = cfg_idx_t'(2);

  localparam logic [MAXIT_W-1:0] MAX_ITER_RST = 8'd20;
  localparam logic [LIMIT_W-1:0] ESC_LIM_RST  = 20'd16;
  localparam logic [LIMIT_W-1:0] INS_LIM_RST  = 20'd4;

  // z component selects
  localparam zsel_t Z_A = zsel_t'(0);
  localparam zsel_t Z_B = zsel_t'(1);
  localparam zsel_t Z_C = zsel_t'(2);
  localparam zsel_t Z_D = zsel_t'(3);

  // microcode addresses
  localparam pc_t PC_TEST   = pc_t'(0);
  localparam pc_t PC_MUL_AB = pc_t'(1);
  localparam pc_t PC_MUL_AC = pc_t'(2);
  localparam pc_t PC_MUL_AD = pc_t'(3);
  localparam pc_t PC_UPD    = pc_t'(4);
  localparam pc_t PC_SQ_A   = pc_t'(5);
  localparam pc_t PC_SQ_B   = pc_t'(6);
  localparam pc_t PC_SQ_C   = pc_t'(7);
  localparam pc_t PC_SQ_D   = pc_t'(8);
  localparam pc_t PC_ACC    = pc_t'(9);
  localparam pc_t PC_FINISH = pc_t'(10);

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_SUB  = 2'd2
  } acc_op_e;

  typedef enum logic [1:0] {
    JMP_NONE    = 2'd0,
    JMP_ALWAYS  = 2'd1,
    JMP_IF_STOP = 2'd2
  } jmp_e;

  typedef struct packed {
    logic    mul_en;
    logic    mul_sq;
    zsel_t   mul_y;
    logic    wbp_en;
    zsel_t   wbp_idx;
    logic    wbr_en;
    logic    iter_inc;
    acc_op_e acc;
    jmp_e    jmp;
    pc_t     target;
    logic    finish;
  } cw_t;

  typedef struct packed {
    logic    start;
    logic    mul_en;
    logic    mul_sq;
    zsel_t   mul_y;
    logic    wbp_en;
    zsel_t   wbp_idx;
    logic    wbr_en;
    logic    iter_inc;
    acc_op_e acc;
    logic    finish;
  } dp_ctrl_t;

  typedef struct packed {
    logic stop;
  } dp_status_t;

  // one iteration: three cross products written back to b, c, d, then a from
  // the stored real part, then the four squares of the new z build norm and r
  function automatic cw_t ucode_rom(input pc_t pc);
    cw_t cw;
    cw = '0;
    cw.acc = ACC_NONE;
    cw.jmp = JMP_NONE;
    case (pc)
      PC_TEST: begin
        cw.jmp    = JMP_IF_STOP;
        cw.target = PC_FINISH;
      end
      PC_MUL_AB: begin
        cw.mul_en = 1'b1;
        cw.mul_y  = Z_B;
      end
      PC_MUL_AC: begin
        cw.mul_en  = 1'b1;
        cw.mul_y   = Z_C;
        cw.wbp_en  = 1'b1;
        cw.wbp_idx = Z_B;
      end
      PC_MUL_AD: begin
        cw.mul_en  = 1'b1;
        cw.mul_y   = Z_D;
        cw.wbp_en  = 1'b1;
        cw.wbp_idx = Z_C;
      end
      PC_UPD: begin
        cw.wbp_en   = 1'b1;
        cw.wbp_idx  = Z_D;
        cw.wbr_en   = 1'b1;
        cw.iter_inc = 1'b1;
      end
      PC_SQ_A: begin
        cw.mul_en = 1'b1;
        cw.mul_sq = 1'b1;
        cw.mul_y  = Z_A;
      end
      PC_SQ_B: begin
        cw.mul_en = 1'b1;
        cw.mul_sq = 1'b1;
        cw.mul_y  = Z_B;
        cw.acc    = ACC_LOAD;
      end
      PC_SQ_C: begin
        cw.mul_en = 1'b1;
        cw.mul_sq = 1'b1;
        cw.mul_y  = Z_C;
        cw.acc    = ACC_SUB;
      end
      PC_SQ_D: begin
        cw.mul_en = 1'b1;
        cw.mul_sq = 1'b1;
        cw.mul_y  = Z_D;
        cw.acc    = ACC_SUB;
      end
      PC_ACC: begin
        cw.acc    = ACC_SUB;
        cw.jmp    = JMP_ALWAYS;
        cw.target = PC_TEST;
      end
      PC_FINISH: begin
        cw.finish = 1'b1;
      end
      default: begin
        cw.finish = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

/* sv/quaternion_escape_time_test.sv */
// top level of the quaternion escape-time test
//
// Input channel (in_valid_i / in_ready_o) transfers one point c as four signed
// Q3.12 components. The block iterates z = z*z + c from z = 0 on one shared
// 24x24 multiplier under a microcode program and answers on the output channel
// (out_valid_o / out_ready_i) with inside_res_o, one result per point.
// Each iteration is a ten-step pass through the program (three cross products,
// the update of z, four squares of the new z, their sum and a test). A point
// runs n iterations, where n is max_iterations, or fewer when |z|^2 passes
// escape_limit_sq first.
// One point is worked on at a time; in_ready_o rises again once the result is
// registered, so the next point may transfer while that result still waits.
// If the receiver stalls, a finished second point holds at its last step
// until the earlier result is taken.
// Reset clears the sequencer to idle with no result pending and loads
// max_iterations 20, escape_limit_sq 16 and inside_limit_sq 4.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once;
// an index beyond the three registers is ignored.
module quaternion_escape_time_test #(
  parameter int unsigned FRAC_BITS  = 12,
  parameter int unsigned WORD_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  qett_pkg::cfg_idx_t               cfg_idx_i,
  input  logic [qett_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [WORD_WIDTH-1:0]     c_real_i,
  input  logic signed [WORD_WIDTH-1:0]     c_i_i,
  input  logic signed [WORD_WIDTH-1:0]     c_j_i,
  input  logic signed [WORD_WIDTH-1:0]     c_k_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             inside_res_o
);
  import qett_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t status;

  qett_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  qett_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .c_real_i     (c_real_i),
    .c_i_i        (c_i_i),
    .c_j_i        (c_j_i),
    .c_k_i        (c_k_i),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .inside_res_o (inside_res_o)
  );

endmodule

/* sv/qett_seq.sv */
// microcode sequencer: step counter, program rom, jumps and channel handshake
module qett_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  qett_pkg::dp_status_t  status_i,
  output qett_pkg::dp_ctrl_t    ctrl_o
);
  import qett_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_e;

  seq_state_e state_q, state_d;
  pc_t        pc_q, pc_d;
  logic       out_valid_q, out_valid_d;
  cw_t        cw;
  logic       start, stall, adv, jump_taken;

  assign cw         = ucode_rom(pc_q);
  assign in_ready_o = (state_q == ST_IDLE);
  assign start      = in_valid_i && in_ready_o;
  // the last step waits while an earlier result has not been taken
  assign stall      = cw.finish && out_valid_q && !out_ready_i;
  assign adv        = (state_q == ST_RUN) && !stall;

  always_comb begin
    case (cw.jmp)
      JMP_ALWAYS:  jump_taken = 1'b1;
      JMP_IF_STOP: jump_taken = status_i.stop;
      default:     jump_taken = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RUN;
          pc_d    = PC_TEST;
        end
      end
      ST_RUN: begin
        if (adv) begin
          if (cw.finish) begin
            state_d     = ST_IDLE;
            out_valid_d = 1'b1;
          end else if (jump_taken) begin
            pc_d = cw.target;
          end else begin
            pc_d = pc_q + pc_t'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= PC_TEST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.acc      = ACC_NONE;
    ctrl_o.start    = start;
    ctrl_o.mul_sq   = cw.mul_sq;
    ctrl_o.mul_y    = cw.mul_y;
    ctrl_o.wbp_idx  = cw.wbp_idx;
    ctrl_o.mul_en   = adv && cw.mul_en;
    ctrl_o.wbp_en   = adv && cw.wbp_en;
    ctrl_o.wbr_en   = adv && cw.wbr_en;
    ctrl_o.iter_inc = adv && cw.iter_inc;
    ctrl_o.finish   = adv && cw.finish;
    if (adv) begin
      ctrl_o.acc = cw.acc;
    end
  end

  a_start_enters_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == ST_RUN) && (pc_q == PC_TEST))
    else $error("transfer in did not start the program at the test step");

  a_hold_only_on_waiting_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && !adv) |-> (out_valid_q && cw.finish))
    else $error("sequencer held without a waiting result");

  a_finish_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && cw.finish) |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("finish step did not present a result");

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (pc_q <= PC_FINISH))
    else $error("step counter left the program");

endmodule

/* sv/qett_dp.sv */
// datapath: config registers, z registers, shared multiplier, norm and real-part accumulators
module qett_dp #(
  parameter int unsigned FRAC_BITS  = 12,
  parameter int unsigned WORD_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  qett_pkg::cfg_idx_t                     cfg_idx_i,
  input  logic [qett_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic signed [WORD_WIDTH-1:0]           c_real_i,
  input  logic signed [WORD_WIDTH-1:0]           c_i_i,
  input  logic signed [WORD_WIDTH-1:0]           c_j_i,
  input  logic signed [WORD_WIDTH-1:0]           c_k_i,
  input  qett_pkg::dp_ctrl_t                     ctrl_i,
  output qett_pkg::dp_status_t                   status_o,
  output logic                                   inside_res_o
);
  import qett_pkg::*;

  localparam int unsigned ZW   = WORD_WIDTH + 8;
  localparam int unsigned PW   = 2 * ZW;
  localparam int unsigned NW   = PW + 1;
  localparam int unsigned SW   = NW + 1;
  localparam int unsigned LIMW = LIMIT_W + 2 * FRAC_BITS;
  localparam int unsigned CMPW = (NW > LIMW) ? NW : LIMW;

  logic [MAXIT_W-1:0] max_q;
  logic [LIMIT_W-1:0] esc_q, ins_q;
  logic [MAXIT_W-1:0] iter_q;
  logic               res_q;

  logic signed [WORD_WIDTH-1:0] c_a_q, c_b_q, c_c_q, c_d_q;
  logic signed [ZW-1:0]         z_a_q, z_b_q, z_c_q, z_d_q;
  logic signed [PW-1:0]         p_q;
  logic signed [NW-1:0]         r_q;
  logic [NW-1:0]                norm_q;

  logic signed [ZW-1:0]         opx, opy, wbp_val, wbr_val;
  logic signed [WORD_WIDTH-1:0] wbp_c;
  logic signed [NW-1:0]         pe, p2;
  logic [LIMW-1:0]              esc_sh, ins_sh;

  // floor shift, add c, saturate to the z range
  function automatic logic signed [ZW-1:0] sat_add(input logic signed [NW-1:0] v,
                                                   input logic signed [WORD_WIDTH-1:0] c);
    logic signed [SW-1:0] sum;
    logic [SW-ZW:0]       top;
    sum = SW'(v >>> FRAC_BITS) + SW'(c);
    top = sum[SW-1:ZW-1];
    if ((&top) || !(|top)) begin
      return sum[ZW-1:0];
    end else if (sum[SW-1]) begin
      return {1'b1, {(ZW-1){1'b0}}};
    end else begin
      return {1'b0, {(ZW-1){1'b1}}};
    end
  endfunction

  always_comb begin
    case (ctrl_i.mul_y)
      Z_A:     opy = z_a_q;
      Z_B:     opy = z_b_q;
      Z_C:     opy = z_c_q;
      default: opy = z_d_q;
    endcase
  end
  assign opx = ctrl_i.mul_sq ? opy : z_a_q;

  always_comb begin
    case (ctrl_i.wbp_idx)
      Z_B:     wbp_c = c_b_q;
      Z_C:     wbp_c = c_c_q;
      default: wbp_c = c_d_q;
    endcase
  end

  assign pe      = NW'(p_q);
  assign p2      = pe <<< 1;
  assign wbp_val = sat_add(p2, wbp_c);
  assign wbr_val = sat_add(r_q, c_a_q);

  assign esc_sh = {esc_q, {(2 * FRAC_BITS){1'b0}}};
  assign ins_sh = {ins_q, {(2 * FRAC_BITS){1'b0}}};

  assign status_o.stop = (CMPW'(norm_q) > CMPW'(esc_sh)) || (iter_q == max_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= MAX_ITER_RST;
      esc_q  <= ESC_LIM_RST;
      ins_q  <= INS_LIM_RST;
      iter_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_ITER: max_q <= cfg_data_i[MAXIT_W-1:0];
          CFG_ESC_LIM:  esc_q <= cfg_data_i[LIMIT_W-1:0];
          CFG_INS_LIM:  ins_q <= cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (ctrl_i.start) begin
        iter_q <= '0;
      end else if (ctrl_i.iter_inc) begin
        iter_q <= iter_q + MAXIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      c_a_q  <= c_real_i;
      c_b_q  <= c_i_i;
      c_c_q  <= c_j_i;
      c_d_q  <= c_k_i;
      z_a_q  <= '0;
      z_b_q  <= '0;
      z_c_q  <= '0;
      z_d_q  <= '0;
      r_q    <= '0;
      norm_q <= '0;
    end else begin
      if (ctrl_i.mul_en) begin
        p_q <= opx * opy;
      end
      if (ctrl_i.wbp_en) begin
        case (ctrl_i.wbp_idx)
          Z_B:     z_b_q <= wbp_val;
          Z_C:     z_c_q <= wbp_val;
          default: z_d_q <= wbp_val;
        endcase
      end
      if (ctrl_i.wbr_en) begin
        z_a_q <= wbr_val;
      end
      case (ctrl_i.acc)
        ACC_LOAD: begin
          r_q    <= pe;
          norm_q <= pe;
        end
        ACC_SUB: begin
          r_q    <= r_q - pe;
          norm_q <= norm_q + pe;
        end
        default: ;
      endcase
    end
    if (ctrl_i.finish) begin
      res_q <= (CMPW'(norm_q) < CMPW'(ins_sh));
    end
  end

  assign inside_res_o = res_q;

endmodule

/* dv/tb_quaternion_escape_time_test.sv */
// self-checking testbench for the quaternion escape-time test block
module tb_quaternion_escape_time_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qett_pkg::*;

  localparam int unsigned FRAC_BITS  = 12;
  localparam int unsigned WORD_WIDTH = 16;
  localparam int unsigned Z_W        = WORD_WIDTH + 8;
  localparam longint      Z_MAX      = (longint'(1) <<< (Z_W - 1)) - 1;
  localparam longint      Z_MIN      = -Z_MAX - 1;
  localparam int unsigned DRAIN_MAX  = 50000;
  localparam int unsigned TAIL_WAIT  = 10 * 255 + 50;
  localparam int unsigned HOLD_LEN   = 1500;

  // index past the register list, must be ignored by the block
  localparam cfg_idx_t CFG_UNUSED = cfg_idx_t'(3);

  typedef logic signed [WORD_WIDTH-1:0] comp_t;
  typedef logic signed [Z_W-1:0]        zcomp_t;
  typedef logic [CFG_DATA_W-1:0]        cfg_data_t;

  typedef struct {
    comp_t re;
    comp_t ii;
    comp_t jj;
    comp_t kk;
  } point_t;

  logic      clk_i;
  logic      rst_ni       = 1'b0;
  logic      cfg_we_i     = 1'b0;
  cfg_idx_t  cfg_idx_i    = CFG_MAX_ITER;
  cfg_data_t cfg_data_i   = '0;
  logic      in_valid_i   = 1'b0;
  logic      in_ready_o;
  comp_t     c_real_i     = '0;
  comp_t     c_i_i        = '0;
  comp_t     c_j_i        = '0;
  comp_t     c_k_i        = '0;
  logic      out_valid_o;
  logic      out_ready_i  = 1'b0;
  logic      inside_res_o;

  quaternion_escape_time_test #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_WIDTH(WORD_WIDTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .c_real_i    (c_real_i),
    .c_i_i       (c_i_i),
    .c_j_i       (c_j_i),
    .c_k_i       (c_k_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .inside_res_o(inside_res_o)
  );

  // predictor copy of the registers and the iteration state
  logic [MAXIT_W-1:0] iter_limit = MAX_ITER_RST;
  logic [LIMIT_W-1:0] esc_limit  = ESC_LIM_RST;
  logic [LIMIT_W-1:0] ins_limit  = INS_LIM_RST;
  zcomp_t             z_now[4]   = '{default: '0};
  logic [MAXIT_W-1:0] iter_done  = '0;

  logic        inside_expected[$];
  int unsigned mismatch_count = 0;

  logic        tx_gaps_on   = 1'b1;
  int unsigned tx_burst_left = 0;
  logic        rx_stall_on  = 1'b1;
  int unsigned rx_hold_len  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic zcomp_t clamp_z(longint v);
    if (v > Z_MAX) return Z_W'(Z_MAX);
    if (v < Z_MIN) return Z_W'(Z_MIN);
    return Z_W'(v);
  endfunction

  // runs the whole orbit of one point and returns the inside flag
  function automatic logic predict_inside(point_t p);
    longint a, b, c, d, r, norm, esc_raw, ins_raw;
    longint cv[4];
    cv[0]   = p.re;
    cv[1]   = p.ii;
    cv[2]   = p.jj;
    cv[3]   = p.kk;
    esc_raw = longint'(esc_limit) << (2 * FRAC_BITS);
    ins_raw = longint'(ins_limit) << (2 * FRAC_BITS);
    norm    = 0;
    for (int n = 0; n < 4; n++) z_now[n] = '0;
    iter_done = '0;
    for (int n = 0; n < int'(iter_limit); n++) begin
      a = z_now[0];
      b = z_now[1];
      c = z_now[2];
      d = z_now[3];
      r = a * a - b * b - c * c - d * d;
      z_now[0] = clamp_z((r >>> FRAC_BITS) + cv[0]);
      z_now[1] = clamp_z(((2 * a * b) >>> FRAC_BITS) + cv[1]);
      z_now[2] = clamp_z(((2 * a * c) >>> FRAC_BITS) + cv[2]);
      z_now[3] = clamp_z(((2 * a * d) >>> FRAC_BITS) + cv[3]);
      iter_done = MAXIT_W'(n + 1);
      norm = 0;
      for (int k = 0; k < 4; k++) norm += longint'(z_now[k]) * longint'(z_now[k]);
      if (norm > esc_raw) break;
    end
    return norm < ins_raw;
  endfunction

  function automatic point_t make_point(int re, int ii, int jj, int kk);
    point_t p;
    p.re = WORD_WIDTH'(re);
    p.ii = WORD_WIDTH'(ii);
    p.jj = WORD_WIDTH'(jj);
    p.kk = WORD_WIDTH'(kk);
    return p;
  endfunction

  // mostly points near the set so orbits run long, some tiny, some raw bits
  function automatic point_t random_point();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      return make_point(int'($urandom_range(0, 10240)) - 8192,
                        int'($urandom_range(0, 8192)) - 4096,
                        int'($urandom_range(0, 4096)) - 2048,
                        int'($urandom_range(0, 4096)) - 2048);
    end else if (sel < 8) begin
      return make_point(int'($urandom_range(0, 4096)) - 2048,
                        int'($urandom_range(0, 4096)) - 2048,
                        int'($urandom_range(0, 4096)) - 2048,
                        int'($urandom_range(0, 4096)) - 2048);
    end
    return make_point($urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic send_point(point_t p);
    if (tx_gaps_on && tx_burst_left == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 18)) @(negedge clk_i);
      tx_burst_left = $urandom_range(1, 8);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    c_real_i   <= p.re;
    c_i_i      <= p.ii;
    c_j_i      <= p.jj;
    c_k_i      <= p.kk;
    do @(posedge clk_i); while (!in_ready_o);
    inside_expected.push_back(predict_inside(p));
    if (tx_burst_left > 0) tx_burst_left--;
  endtask

  // lets every pending result come back; leftovers after the limit are failures
  task automatic drain_results();
    int unsigned waited;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    waited = 0;
    while (inside_expected.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk_i);
      waited++;
    end
    if (inside_expected.size() != 0) begin
      $display("%0t: results still pending, expected 0, actual %0d",
               $time, inside_expected.size());
      mismatch_count++;
      inside_expected.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_MAX_ITER: iter_limit = data[MAXIT_W-1:0];
      CFG_ESC_LIM:  esc_limit  = data[LIMIT_W-1:0];
      CFG_INS_LIM:  ins_limit  = data[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [MAXIT_W-1:0] maxit, logic [LIMIT_W-1:0] esc,
                            logic [LIMIT_W-1:0] ins);
    drain_results();
    // junk above the 8-bit field must be dropped
    write_reg(CFG_MAX_ITER, {12'($urandom), maxit});
    write_reg(CFG_ESC_LIM, esc);
    write_reg(CFG_INS_LIM, ins);
  endtask

  always @(posedge clk_i) begin : result_check
    logic want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (inside_expected.size() == 0) begin
        $display("%0t: result with none pending, expected none, actual %0b",
                 $time, inside_res_o);
        mismatch_count++;
      end else begin
        want = inside_expected.pop_front();
        if (inside_res_o !== want) begin
          $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                   $time, want, inside_res_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : receiver
    logic [15:0] rx_mask;
    int unsigned rx_pos;
    rx_mask = 16'hFFFF;
    rx_pos  = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_len > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_len--;
      end else if (!rx_stall_on) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= rx_mask[rx_pos];
        rx_pos = (rx_pos + 1) % 16;
        if (rx_pos == 0 && $urandom_range(0, 3) == 0) begin
          rx_mask = ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom & $urandom))
                    | 16'h0001;
        end
      end
    end
  end

  task automatic test_default_settings();
    send_point(make_point(0, 0, 0, 0));
    send_point(make_point(-4096, 0, 0, 0));
    send_point(make_point(1024, 0, 0, 0));
    send_point(make_point(32767, 32767, 32767, 32767));
    send_point(make_point(-32768, -32768, -32768, -32768));
    send_point(make_point(0, 4096, 0, 0));
    send_point(make_point(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    send_point(make_point(-32768, 32767, -32768, 32767));
  endtask

  // limits so high that components clip before the escape test fires
  task automatic test_saturation();
    set_config(12, 20'hFFFFF, 20'hFFFFF);
    send_point(make_point(32767, 32767, 32767, 32767));
    send_point(make_point(-32768, -32768, -32768, -32768));
    send_point(make_point(-32768, 0, 0, 0));
    send_point(make_point(0, 32767, 0, 0));
  endtask

  task automatic test_zero_iterations();
    set_config(0, 16, 4);
    send_point(make_point(0, 0, 0, 0));
    send_point(make_point(32767, -32768, 32767, -32768));
    set_config(0, 16, 0);
    send_point(make_point(0, 0, 0, 0));
  endtask

  task automatic test_zero_limits();
    set_config(20, 0, 0);
    send_point(make_point(4096, 0, 0, 0));
    set_config(20, 0, 1);
    send_point(make_point(0, 0, 0, 0));
    send_point(make_point(1, 0, 0, 0));
  endtask

  task automatic test_unused_index();
    set_config(20, 16, 4);
    drain_results();
    write_reg(CFG_UNUSED, 20'hFFFFF);
    send_point(make_point(-4096, 0, 0, 0));
  endtask

  task automatic test_long_orbits();
    set_config(255, 20'hFFFFF, 4);
    send_point(make_point(0, 0, 0, 0));
    send_point(make_point(-4096, 0, 0, 0));
    send_point(make_point(-7168, 0, 0, 0));
  endtask

  // receiver holds off long enough that the block fills and stops taking points
  task automatic test_receiver_hold();
    set_config(20, 16, 4);
    tx_gaps_on  = 1'b0;
    rx_hold_len = HOLD_LEN;
    for (int n = 0; n < 6; n++) send_point(random_point());
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_points();
    logic [MAXIT_W-1:0] maxit;
    logic [LIMIT_W-1:0] esc, ins;
    int unsigned        count;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0:       maxit = 1;
        1:       maxit = 255;
        2:       maxit = 0;
        default: maxit = MAXIT_W'($urandom_range(2, 40));
      endcase
      case ($urandom_range(0, 5))
        0:       esc = 0;
        1:       esc = 4;
        2:       esc = 16;
        3:       esc = 20'hFFFFF;
        default: esc = LIMIT_W'($urandom_range(1, 400));
      endcase
      case ($urandom_range(0, 5))
        0:       ins = 0;
        1:       ins = 1;
        2:       ins = 4;
        3:       ins = 20'hFFFFF;
        default: ins = LIMIT_W'($urandom_range(1, 64));
      endcase
      set_config(maxit, esc, ins);
      tx_gaps_on  = (ph % 3) != 1;
      rx_stall_on = (ph % 4) != 2;
      count = (ph == 1) ? 8 : 55;
      for (int n = 0; n < count; n++) send_point(random_point());
    end
    rx_stall_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_settings();
    test_saturation();
    test_zero_iterations();
    test_zero_limits();
    test_unused_index();
    test_long_orbits();
    test_receiver_hold();
    test_random_points();

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
